### hw/rtl/avcab_pkg.sv
// ----------------------------------------------------------------------------
// avcab_pkg: shared types and constants for the avcC to Annex B converter
// Parse phases, status codes, the request passed from the parser to the
// emitter and the output item layout.
// ----------------------------------------------------------------------------
package avcab_pkg;

    // parse phases of one configuration record
    typedef enum logic [2:0] {
        PH_SKIP    = 3'd0,
        PH_LSIZE   = 3'd1,
        PH_SPSCNT  = 3'd2,
        PH_SIZE_HI = 3'd3,
        PH_SIZE_LO = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_PPSCNT  = 3'd6,
        PH_DRAIN   = 3'd7
    } phase_t;

    // summary status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERRUN = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;

    // register word index on the config port
    localparam int         APB_ADDR_W         = 3;
    localparam logic       REG_IDX_RECORD_LEN = 1'b0;
    localparam logic       REG_IDX_PAD_BYTES  = 1'b1;

    // reset values of the config registers
    localparam logic [15:0] RECORD_LEN_RST = 16'hffff;
    localparam logic [5:0]  PAD_BYTES_RST  = 6'd32;

    // padding saturates here
    localparam logic [5:0]  MAX_PAD = 6'd32;

    // start code 00 00 00 01
    localparam logic [2:0]  SC_LEN         = 3'd4;
    localparam logic [7:0]  START_CODE_HEAD = 8'h00;
    localparam logic [7:0]  START_CODE_TAIL = 8'h01;

    // skip bytes before the length size byte
    localparam logic [15:0] HDR_LAST_POS = 16'd3;

    // one request: all results that a single record byte causes, in order
    // start code or payload byte, then padding, then summary
    typedef struct packed {
        logic       sc_vld;
        logic       pay_vld;
        logic [7:0] pay_byte;
        logic [5:0] pad_cnt;
        logic       sum_vld;
        logic [1:0] status;
        logic [2:0] lsize;
        logic       sps;
        logic       pps;
    } cmd_t;

    // one output item
    typedef struct packed {
        logic [7:0] data;
        logic       is_summary;
        logic [2:0] lsize;
        logic       sps;
        logic       pps;
        logic [1:0] status;
        logic       last;
    } out_item_t;

endpackage

### hw/rtl/avcab_front.sv
// ----------------------------------------------------------------------------
// avcab_front: record parser
// Takes one record byte a cycle while the request queue has room, tracks the
// parse phase and turns each byte into one request describing the output items it causes.
// ----------------------------------------------------------------------------
module avcab_front
    import avcab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic [15:0] record_len,
    input  logic [5:0]  pad_bytes,
    input  logic        q_full,
    output logic        push,
    output cmd_t        cmd
);

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  units_reg, units_next;
    logic [15:0] pay_left_reg, pay_left_next;
    logic [7:0]  size_hi_reg, size_hi_next;
    logic [2:0]  lsize_reg, lsize_next;
    logic        in_pps_reg, in_pps_next;
    logic        sps_reg, sps_next;
    logic        pps_reg, pps_next;

    logic        accept;
    logic        end_unit;
    logic        finish;
    logic        overrun;
    logic        rec_end;
    logic [15:0] usize;
    logic [5:0]  pad_sat;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign usize    = {size_hi_reg, in_byte};
    assign overrun  = ({1'b0, pos_reg} + 17'd1 + {1'b0, usize}) > {1'b0, record_len};
    assign pad_sat  = (pad_bytes > MAX_PAD) ? MAX_PAD : pad_bytes;

    // only requests that produce output go to the queue
    assign push = accept && (cmd.sc_vld || cmd.pay_vld || (cmd.pad_cnt != 6'd0) || cmd.sum_vld);

    // phase decode and request build
    always_comb
    begin
        phase_next    = phase_reg;
        units_next    = units_reg;
        pay_left_next = pay_left_reg;
        size_hi_next  = size_hi_reg;
        lsize_next    = lsize_reg;
        in_pps_next   = in_pps_reg;
        sps_next      = sps_reg;
        pps_next      = pps_reg;
        cmd           = '0;
        end_unit      = 1'b0;
        finish        = 1'b0;

        unique case (phase_reg)
            PH_SKIP:
            begin
                if (pos_reg >= HDR_LAST_POS)
                    phase_next = PH_LSIZE;
            end
            PH_LSIZE:
            begin
                lsize_next = {1'b0, in_byte[1:0]} + 3'd1;
                phase_next = PH_SPSCNT;
            end
            PH_SPSCNT:
            begin
                units_next = {3'b000, in_byte[4:0]};
                if (in_byte[4:0] != 5'd0)
                begin
                    sps_next   = 1'b1;
                    phase_next = PH_SIZE_HI;
                end
                else
                    phase_next = PH_PPSCNT;
            end
            PH_SIZE_HI:
            begin
                size_hi_next = in_byte;
                phase_next   = PH_SIZE_LO;
            end
            PH_SIZE_LO:
            begin
                if (overrun)
                begin
                    cmd.sum_vld = 1'b1;
                    cmd.status  = ST_OVERRUN;
                    phase_next  = PH_DRAIN;
                end
                else
                begin
                    cmd.sc_vld    = 1'b1;
                    pay_left_next = usize;
                    if (usize == 16'd0)
                        end_unit = 1'b1;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                cmd.pay_vld   = 1'b1;
                cmd.pay_byte  = in_byte;
                pay_left_next = pay_left_reg - 16'd1;
                if (pay_left_next == 16'd0)
                    end_unit = 1'b1;
            end
            PH_PPSCNT:
            begin
                units_next  = in_byte;
                in_pps_next = 1'b1;
                if (in_byte != 8'd0)
                begin
                    pps_next   = 1'b1;
                    phase_next = PH_SIZE_HI;
                end
                else
                    finish = 1'b1;
            end
            PH_DRAIN:
            begin
                phase_next = PH_DRAIN;
            end
            default:
            begin
                phase_next = PH_DRAIN;
            end
        endcase

        // unit done: next unit, pps section or record done
        if (end_unit)
        begin
            units_next = units_reg - 8'd1;
            if (units_next != 8'd0)
                phase_next = PH_SIZE_HI;
            else if (!in_pps_reg)
                phase_next = PH_PPSCNT;
            else
                finish = 1'b1;
        end

        // clean finish: padding when any unit was announced, then summary
        if (finish)
        begin
            cmd.pad_cnt = (sps_next || pps_next) ? pad_sat : 6'd0;
            cmd.sum_vld = 1'b1;
            cmd.status  = ST_OK;
            phase_next  = PH_DRAIN;
        end

        // byte position saturates at its top value
        pos_next = (pos_reg != 16'hffff) ? pos_reg + 16'd1 : pos_reg;
        rec_end  = pos_next >= record_len;

        // record ran out before the parse was done
        if (rec_end && (phase_next != PH_DRAIN))
        begin
            cmd.sum_vld = 1'b1;
            cmd.status  = ST_SHORT;
        end

        cmd.lsize = lsize_next;
        cmd.sps   = sps_next;
        cmd.pps   = pps_next;

        // end of record clears all per-record state
        if (rec_end)
        begin
            phase_next    = PH_SKIP;
            pos_next      = 16'd0;
            units_next    = 8'd0;
            pay_left_next = 16'd0;
            size_hi_next  = 8'd0;
            lsize_next    = 3'd0;
            in_pps_next   = 1'b0;
            sps_next      = 1'b0;
            pps_next      = 1'b0;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SKIP;
            pos_reg      <= 16'd0;
            units_reg    <= 8'd0;
            pay_left_reg <= 16'd0;
            size_hi_reg  <= 8'd0;
            lsize_reg    <= 3'd0;
            in_pps_reg   <= 1'b0;
            sps_reg      <= 1'b0;
            pps_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            units_reg    <= units_next;
            pay_left_reg <= pay_left_next;
            size_hi_reg  <= size_hi_next;
            lsize_reg    <= lsize_next;
            in_pps_reg   <= in_pps_next;
            sps_reg      <= sps_next;
            pps_reg      <= pps_next;
        end
    end

    // a request never carries both a start code and a payload byte
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !(cmd.sc_vld && cmd.pay_vld))
        else $error("request with start code and payload byte");

    // padding only ahead of a clean summary
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && (cmd.pad_cnt != 6'd0)) |-> (cmd.sum_vld && (cmd.status == ST_OK)))
        else $error("padding without clean summary");

endmodule

### hw/rtl/avcab_queue.sv
// ----------------------------------------------------------------------------
// avcab_queue: request queue
// Short first-in first-out buffer of requests between parser and emitter.
// ----------------------------------------------------------------------------
module avcab_queue
    import avcab_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_data,
    input  logic pop,
    output cmd_t rd_data,
    output logic full,
    output logic not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    // no write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overflow");

    // no read from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("queue underflow");

endmodule

### hw/rtl/avcab_back.sv
// ----------------------------------------------------------------------------
// avcab_back: item emitter
// Expands each request into its output items, one per cycle unless the
// output stalls, into an output register with valid and ready.
// ----------------------------------------------------------------------------
module avcab_back
    import avcab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  logic      cmd_vld,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t item
);

    cmd_t       cur_reg, cur_next, cur_after;
    logic [2:0] sc_left_reg, sc_left_next, sc_after;
    logic       out_valid_reg, out_valid_next;
    out_item_t  item_reg, item_next;

    logic       busy;
    logic       after_busy;
    logic       advance;

    assign busy = (sc_left_reg != 3'd0) || cur_reg.pay_vld || (cur_reg.pad_cnt != 6'd0)
                  || cur_reg.sum_vld;
    assign advance   = busy && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign item      = item_reg;

    // pick the next item of the current request
    always_comb
    begin
        item_next = '0;
        cur_after = cur_reg;
        sc_after  = sc_left_reg;
        if (sc_left_reg != 3'd0)
        begin
            item_next.data = (sc_left_reg == 3'd1) ? START_CODE_TAIL : START_CODE_HEAD;
            sc_after       = sc_left_reg - 3'd1;
        end
        else if (cur_reg.pay_vld)
        begin
            item_next.data    = cur_reg.pay_byte;
            cur_after.pay_vld = 1'b0;
        end
        else if (cur_reg.pad_cnt != 6'd0)
        begin
            cur_after.pad_cnt = cur_reg.pad_cnt - 6'd1;
        end
        else if (cur_reg.sum_vld)
        begin
            item_next.is_summary = 1'b1;
            item_next.lsize      = cur_reg.lsize;
            item_next.sps        = cur_reg.sps;
            item_next.pps        = cur_reg.pps;
            item_next.status     = cur_reg.status;
            item_next.last       = 1'b1;
            cur_after.sum_vld    = 1'b0;
        end
        after_busy = (sc_after != 3'd0) || cur_after.pay_vld || (cur_after.pad_cnt != 6'd0)
                     || cur_after.sum_vld;
    end

    // take the next request as the current one runs out
    assign pop = cmd_vld && (!busy || (advance && !after_busy));

    always_comb
    begin
        cur_next     = cur_reg;
        sc_left_next = sc_left_reg;
        if (pop)
        begin
            cur_next     = cmd;
            sc_left_next = cmd.sc_vld ? SC_LEN : 3'd0;
        end
        else if (advance)
        begin
            cur_next     = cur_after;
            sc_left_next = sc_after;
        end
        out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            sc_left_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            sc_left_reg   <= sc_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (advance)
            item_reg <= item_next;
    end

    // a stalled output holds the request being expanded
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && busy) |=> ($stable(sc_left_reg) && $stable(cur_reg)))
        else $error("request advanced under output stall");

endmodule

### hw/rtl/avcc_config_record_to_annexb.sv
// ----------------------------------------------------------------------------
// avcc_config_record_to_annexb: avcC configuration record to Annex B
// Top level: config registers, parser, request queue and emitter.
// ----------------------------------------------------------------------------
// One record byte is taken per cycle while the request queue has room. Each
// byte that causes output items becomes one request; header and count bytes
// that cause none leave no request. The emitter sends one output item per
// cycle unless out_ready stalls it, so a byte that causes N items (start code
// of four bytes, payload byte, up to 32 padding bytes and the summary) keeps
// the emitter busy while the parser runs ahead by up to QUEUE_DEPTH requests.
// With the emitter idle, the first item of a byte is registered in the request
// queue, the emitter's current request and the output register, in that order.
// Registers: record_len at byte address 0, pad_bytes at byte address 4.
module avcc_config_record_to_annexb
    import avcab_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  is_summary,
    output logic [2:0]            nal_length_size,
    output logic                  sps_present,
    output logic                  pps_present,
    output logic [1:0]            status,
    output logic                  last
);

    logic [15:0] record_len_reg;
    logic [5:0]  pad_bytes_reg;
    logic        cfg_wr;

    cmd_t        q_wr_data;
    cmd_t        q_rd_data;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_not_empty;
    out_item_t   item;

    // config register write and read back
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_len_reg <= RECORD_LEN_RST;
            pad_bytes_reg  <= PAD_BYTES_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_IDX_RECORD_LEN: record_len_reg <= pwdata[15:0];
                REG_IDX_PAD_BYTES:  pad_bytes_reg  <= pwdata[5:0];
                default:            record_len_reg <= record_len_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_IDX_RECORD_LEN: prdata = {16'd0, record_len_reg};
            REG_IDX_PAD_BYTES:  prdata = {26'd0, pad_bytes_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // parser
    avcab_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .record_len (record_len_reg),
        .pad_bytes  (pad_bytes_reg),
        .q_full     (q_full),
        .push       (q_push),
        .cmd        (q_wr_data)
    );

    // request queue
    avcab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_data   (q_wr_data),
        .pop       (q_pop),
        .rd_data   (q_rd_data),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    // emitter
    avcab_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_rd_data),
        .cmd_vld   (q_not_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .item      (item)
    );

    assign out_byte        = item.data;
    assign is_summary      = item.is_summary;
    assign nal_length_size = item.lsize;
    assign sps_present     = item.sps;
    assign pps_present     = item.pps;
    assign status          = item.status;
    assign last            = item.last;

endmodule

### tb/sv/tb_avcc_config_record_to_annexb.sv
// ----------------------------------------------------------------------------
// tb_avcc_config_record_to_annexb: self-checking bench for the avcC converter
// Builds configuration records byte by byte, runs them through the block with
// random gaps and stalls on both sides, predicts the Annex B bytes, padding and
// summary item of every record and checks each output item in order.
// ----------------------------------------------------------------------------
module tb_avcc_config_record_to_annexb;
    import avcab_pkg::*;

    localparam int RANDOM_BYTES    = 200;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            in_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            out_byte;
    logic                  is_summary;
    logic [2:0]            nal_length_size;
    logic                  sps_present;
    logic                  pps_present;
    logic [1:0]            status;
    logic                  last;

    // predictor state, one copy of the parser
    phase_t      ph;
    logic [15:0] pos;
    logic [7:0]  units;
    logic [15:0] pay_left;
    logic [7:0]  size_hi;
    logic [2:0]  lsize;
    bit          in_pps;
    bit          sps_announced;
    bit          pps_announced;
    logic [15:0] cfg_record_len;
    logic [5:0]  cfg_pad;

    out_item_t   annexb_q[$];
    logic [7:0]  rec_q[$];
    int          mismatches;
    bit          steady;
    bit          hold_req;

    avcc_config_record_to_annexb dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .is_summary      (is_summary),
        .nal_length_size (nal_length_size),
        .sps_present     (sps_present),
        .pps_present     (pps_present),
        .status          (status),
        .last            (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_parse();
        ph            = PH_SKIP;
        pos           = '0;
        units         = '0;
        pay_left      = '0;
        size_hi       = '0;
        lsize         = '0;
        in_pps        = 1'b0;
        sps_announced = 1'b0;
        pps_announced = 1'b0;
    endfunction

    function automatic void push_annexb_byte(input logic [7:0] b);
        out_item_t item;
        item = '0;
        item.data = b;
        annexb_q.push_back(item);
    endfunction

    function automatic void push_summary(input logic [1:0] st);
        out_item_t item;
        item = '0;
        item.is_summary = 1'b1;
        item.lsize      = lsize;
        item.sps        = sps_announced;
        item.pps        = pps_announced;
        item.status     = st;
        item.last       = 1'b1;
        annexb_q.push_back(item);
    endfunction

    // padding only when some unit was announced, then the summary
    function automatic void finish_sets();
        logic [5:0] npad;
        npad = (cfg_pad > MAX_PAD) ? MAX_PAD : cfg_pad;
        if (sps_announced || pps_announced)
        begin
            for (int i = 0; i < npad; i++)
                push_annexb_byte(8'h00);
        end
        push_summary(ST_OK);
        ph = PH_DRAIN;
    endfunction

    function automatic void close_unit();
        units = units - 8'd1;
        if (units != 0)
            ph = PH_SIZE_HI;
        else if (!in_pps)
            ph = PH_PPSCNT;
        else
            finish_sets();
    endfunction

    // expected output items for one accepted record byte
    function automatic void predict_annexb(input logic [7:0] b);
        logic [15:0] usize;
        case (ph)
            PH_SKIP:
            begin
                if (pos >= HDR_LAST_POS)
                    ph = PH_LSIZE;
            end
            PH_LSIZE:
            begin
                lsize = {1'b0, b[1:0]} + 3'd1;
                ph    = PH_SPSCNT;
            end
            PH_SPSCNT:
            begin
                units = {3'b000, b[4:0]};
                if (units != 0)
                begin
                    sps_announced = 1'b1;
                    ph            = PH_SIZE_HI;
                end
                else
                    ph = PH_PPSCNT;
            end
            PH_SIZE_HI:
            begin
                size_hi = b;
                ph      = PH_SIZE_LO;
            end
            PH_SIZE_LO:
            begin
                usize = {size_hi, b};
                if (int'(pos) + 1 + int'(usize) > int'(cfg_record_len))
                begin
                    push_summary(ST_OVERRUN);
                    ph = PH_DRAIN;
                end
                else
                begin
                    for (int i = 0; i < SC_LEN - 1; i++)
                        push_annexb_byte(START_CODE_HEAD);
                    push_annexb_byte(START_CODE_TAIL);
                    pay_left = usize;
                    if (usize == 0)
                        close_unit();
                    else
                        ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                push_annexb_byte(b);
                pay_left = pay_left - 16'd1;
                if (pay_left == 0)
                    close_unit();
            end
            PH_PPSCNT:
            begin
                units  = b;
                in_pps = 1'b1;
                if (units != 0)
                begin
                    pps_announced = 1'b1;
                    ph            = PH_SIZE_HI;
                end
                else
                    finish_sets();
            end
            default:
            begin
                ph = PH_DRAIN;
            end
        endcase

        if (pos < 16'hffff)
            pos = pos + 16'd1;

        // end of record: short summary unless already done, then start over
        if (pos >= cfg_record_len)
        begin
            if (ph != PH_DRAIN)
                push_summary(ST_SHORT);
            clear_parse();
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    // mostly short gaps, a few long ones, none in steady stretches
    function automatic int idle_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // register write, then read back
    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] mask;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_IDX_RECORD_LEN)
        begin
            cfg_record_len = value[15:0];
            mask = 32'h0000_ffff;
        end
        else
        begin
            cfg_pad = value[5:0];
            mask = 32'h0000_003f;
        end
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== (value & mask))
            report_mismatch("register readback", readback, value & mask);
    endtask

    // one record byte over the request channel
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte  = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_annexb(b);
    endtask

    // a zero-length record still takes one byte
    task automatic send_record(input int count);
        int n;
        n = (count == 0) ? 1 : count;
        for (int i = 0; i < n; i++)
            send_byte((i < rec_q.size()) ? rec_q[i] : 8'($urandom));
    endtask

    // stop offering, let every expected item out, let the parser settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (annexb_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_record(input int rlen, input int pad);
        wait_idle();
        write_reg(REG_IDX_RECORD_LEN, 32'(rlen));
        write_reg(REG_IDX_PAD_BYTES, 32'(pad));
        send_record(rlen);
    endtask

    // four random header bytes and a random length size byte
    function automatic void begin_record();
        rec_q.delete();
        repeat (5) rec_q.push_back(8'($urandom));
    endfunction

    function automatic void add_unit(input int size);
        rec_q.push_back(8'(size >> 8));
        rec_q.push_back(8'(size));
        repeat (size) rec_q.push_back(8'($urandom));
    endfunction

    function automatic int pick_unit_size();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(7, 40);
        return $urandom_range(0, 6);
    endfunction

    // ---------------------------------------------------------------- tests

    // reset register values: long record, full padding, then drain to realign
    task automatic test_reset_defaults();
        begin_record();
        rec_q[4] = 8'hff;
        rec_q.push_back(8'he1);
        add_unit(0);
        rec_q.push_back(8'h00);
        send_record(rec_q.size());
        run_record(1, 32);
    endtask

    // no sps and no pps: summary only
    task automatic test_no_units();
        begin_record();
        rec_q[4] = 8'h00;
        rec_q.push_back(8'h00);
        rec_q.push_back(8'h00);
        run_record(7, 20);
    endtask

    // largest unit size runs past the record
    task automatic test_overrun();
        begin_record();
        rec_q.push_back(8'h1f);
        rec_q.push_back(8'hff);
        rec_q.push_back(8'hff);
        run_record(12, 5);
    endtask

    // record ends in the header, before the pps count, in a size, or is empty
    task automatic test_early_end();
        begin_record();
        run_record(0, 5);
        run_record(3, 5);
        rec_q.push_back(8'h01);
        add_unit(0);
        run_record(8, 5);
        begin_record();
        rec_q.push_back(8'h00);
        rec_q.push_back(8'hff);
        add_unit(1);
        run_record(8, 5);
    endtask

    // padding above the limit saturates, and zero padding
    task automatic test_padding_limits();
        begin_record();
        rec_q.push_back(8'h01);
        add_unit(2);
        rec_q.push_back(8'h01);
        add_unit(1);
        run_record(rec_q.size(), 63);
        run_record(rec_q.size(), 0);
    endtask

    // receiver holds off while the sender streams a long record
    task automatic test_backpressure();
        begin_record();
        rec_q.push_back(8'h01);
        add_unit(24);
        rec_q.push_back(8'h01);
        add_unit(3);
        wait_idle();
        write_reg(REG_IDX_RECORD_LEN, 32'(rec_q.size()));
        write_reg(REG_IDX_PAD_BYTES, 32'd32);
        steady   = 1'b1;
        hold_req = 1'b1;
        send_record(rec_q.size());
        steady   = 1'b0;
    endtask

    // mostly well-formed records, some cut short, some noise
    task automatic test_random_records();
        int structured;
        int shape;
        int n_sps;
        int n_pps;
        int rlen;
        int pad;
        int full;
        structured = 0;
        while (structured < RANDOM_BYTES)
        begin
            shape  = $urandom_range(0, 9);
            steady = ($urandom_range(0, 5) == 0);
            begin_record();
            if (shape == 9)
            begin
                repeat (7) rec_q.push_back(8'($urandom));
                rlen = $urandom_range(0, 12);
            end
            else
            begin
                n_sps = ($urandom_range(0, 15) == 0) ? 31 : $urandom_range(0, 3);
                rec_q.push_back({3'($urandom), 5'(n_sps)});
                for (int i = 0; i < n_sps; i++)
                    add_unit((n_sps == 31) ? 0 : pick_unit_size());
                n_pps = $urandom_range(0, 3);
                rec_q.push_back(8'(n_pps));
                for (int i = 0; i < n_pps; i++)
                    add_unit(pick_unit_size());
                full = rec_q.size();
                if (shape >= 7)
                    rlen = $urandom_range(1, full - 1);
                else
                    rlen = full + $urandom_range(0, 3);
            end
            pad = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32);
            run_record(rlen, pad);
            structured += (rlen < rec_q.size()) ? ((rlen == 0) ? 1 : rlen) : rec_q.size();
        end
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- main

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        in_byte    = '0;
        mismatches = 0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        cfg_record_len = RECORD_LEN_RST;
        cfg_pad        = PAD_BYTES_RST;
        clear_parse();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_no_units();
        test_overrun();
        test_early_end();
        test_padding_limits();
        test_backpressure();
        test_random_records();

        @(negedge clk);
        in_valid = 1'b0;
        while (annexb_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && annexb_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            stall = idle_gap();
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    // compare every output item with the oldest expectation
    always @(posedge clk)
    begin : check_items
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (annexb_q.size() == 0)
                report_mismatch("unexpected item, out_byte", out_byte, 0);
            else
            begin
                want = annexb_q.pop_front();
                if (out_byte !== want.data)
                    report_mismatch("out_byte", out_byte, want.data);
                if (is_summary !== want.is_summary)
                    report_mismatch("is_summary", is_summary, want.is_summary);
                if (nal_length_size !== want.lsize)
                    report_mismatch("nal_length_size", nal_length_size, want.lsize);
                if (sps_present !== want.sps)
                    report_mismatch("sps_present", sps_present, want.sps);
                if (pps_present !== want.pps)
                    report_mismatch("pps_present", pps_present, want.pps);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d quiet cycles", quiet);
        $display("== FAIL ==");
        $finish;
    end

endmodule
